FILE: design/qrm_pkg.sv
`timescale 1ns / 1ps
package qrm_pkg;

	localparam int LANES  = 9;
	localparam int IN_W   = 16;
	localparam int PROD_W = 2 * IN_W;
	localparam int S_W    = PROD_W + 1;
	localparam int N_W    = PROD_W + 2;
	localparam int Q_W    = 16;
	localparam int OUT_W  = 16;

	localparam logic [Q_W-1:0] ONE_Q14 = Q_W'(16384);

	typedef struct packed {
		logic [S_W-1:0]            s;
		logic [LANES-1:0]          neg;
		logic [LANES-1:0][S_W-1:0] mag;
		logic                      deg;
	} qrm_div_in_t;

	typedef struct packed {
		logic [LANES-1:0]          neg;
		logic [LANES-1:0][Q_W-1:0] quo;
		logic                      deg;
	} qrm_div_out_t;

	typedef struct packed {
		logic [LANES-1:0][OUT_W-1:0] m;
		logic                        deg;
	} qrm_mat_t;

endpackage

FILE: design/qrm_front.sv
`timescale 1ns / 1ps
module qrm_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [15:0]       qx,
	input  logic signed [15:0]       qy,
	input  logic signed [15:0]       qz,
	input  logic signed [15:0]       qw,
	output logic                     out_valid,
	input  logic                     out_ready,
	output qrm_pkg::qrm_div_in_t     out_word
);
	import qrm_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic ld_s1, ld_s2, ld_s3;

	logic signed [PROD_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PROD_W-1:0] xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;
	logic                     deg_s1;

	logic [S_W-1:0]                   s_s2;
	logic [LANES-1:0][N_W-1:0]        n_s2;
	logic                             deg_s2;

	logic signed [N_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw, ssum;
	logic [LANES-1:0][N_W-1:0] n_nxt;
	logic [LANES-1:0][S_W-1:0] mag_nxt;
	logic [LANES-1:0]          neg_nxt;

	qrm_div_in_t word_s3;

	assign ld_s3    = !vld_s3 || out_ready;
	assign ld_s2    = !vld_s2 || ld_s3;
	assign ld_s1    = !vld_s1 || ld_s2;
	assign in_ready = ld_s1;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			xx_s1  <= qx * qx;
			yy_s1  <= qy * qy;
			zz_s1  <= qz * qz;
			ww_s1  <= qw * qw;
			xy_s1  <= qx * qy;
			xz_s1  <= qx * qz;
			yz_s1  <= qy * qz;
			xw_s1  <= qx * qw;
			yw_s1  <= qy * qw;
			zw_s1  <= qz * qw;
			deg_s1 <= (qx == '0) && (qy == '0) && (qz == '0) && (qw == '0);
		end
	end

	// stage 2: sum of squares and numerators
	always_comb begin
		exx  = N_W'(xx_s1);
		eyy  = N_W'(yy_s1);
		ezz  = N_W'(zz_s1);
		eww  = N_W'(ww_s1);
		exy  = N_W'(xy_s1);
		exz  = N_W'(xz_s1);
		eyz  = N_W'(yz_s1);
		exw  = N_W'(xw_s1);
		eyw  = N_W'(yw_s1);
		ezw  = N_W'(zw_s1);
		ssum = exx + eyy + ezz + eww;
		n_nxt[0] = exx + eww - eyy - ezz;
		n_nxt[1] = (exy - ezw) <<< 1;
		n_nxt[2] = (exz + eyw) <<< 1;
		n_nxt[3] = (exy + ezw) <<< 1;
		n_nxt[4] = eyy + eww - exx - ezz;
		n_nxt[5] = (eyz - exw) <<< 1;
		n_nxt[6] = (exz - eyw) <<< 1;
		n_nxt[7] = (eyz + exw) <<< 1;
		n_nxt[8] = ezz + eww - exx - eyy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			s_s2   <= ssum[S_W-1:0];
			n_s2   <= n_nxt;
			deg_s2 <= deg_s1;
		end
	end

	// stage 3: sign and magnitude
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			neg_nxt[l] = n_s2[l][N_W-1];
			mag_nxt[l] = neg_nxt[l] ? S_W'(-n_s2[l]) : n_s2[l][S_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ld_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			word_s3.s   <= s_s2;
			word_s3.neg <= neg_nxt;
			word_s3.mag <= mag_nxt;
			word_s3.deg <= deg_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_word  = word_s3;

`ifndef NO_ASSERTIONS
	a_deg_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (deg_s2 == (s_s2 == '0)))
		else $error("degenerate flag disagrees with sum of squares");
`endif

endmodule

FILE: design/qrm_divider.sv
`timescale 1ns / 1ps
module qrm_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qrm_pkg::qrm_div_in_t  in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qrm_pkg::qrm_div_out_t out_word
);
	import qrm_pkg::*;

	localparam int STAGES = Q_W;

	logic [STAGES-1:0]                        vld_s;
	logic [STAGES-1:0]                        load;
	logic [STAGES-1:0][S_W-1:0]               div_s;
	logic [STAGES-1:0][LANES-1:0][S_W-1:0]    rem_s;
	logic [STAGES-1:0][LANES-1:0][Q_W-1:0]    quo_s;
	logic [STAGES-1:0][LANES-1:0]             neg_s;
	logic [STAGES-1:0]                        deg_s;

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic                            prv_v;
		logic [S_W-1:0]                  prv_d;
		logic [LANES-1:0][S_W-1:0]       prv_r;
		logic [LANES-1:0][Q_W-1:0]       prv_q;
		logic [LANES-1:0]                prv_n;
		logic                            prv_g;
		logic                            nxt_rdy;
		logic [LANES-1:0][S_W-1:0]       nxt_r;
		logic [LANES-1:0][Q_W-1:0]       nxt_q;

		if (k == 0) begin : g_head
			assign prv_v = in_valid;
			assign prv_d = in_word.s;
			assign prv_r = in_word.mag;
			assign prv_q = '0;
			assign prv_n = in_word.neg;
			assign prv_g = in_word.deg;
		end else begin : g_body
			assign prv_v = vld_s[k-1];
			assign prv_d = div_s[k-1];
			assign prv_r = rem_s[k-1];
			assign prv_q = quo_s[k-1];
			assign prv_n = neg_s[k-1];
			assign prv_g = deg_s[k-1];
		end

		if (k == STAGES - 1) begin : g_tail
			assign nxt_rdy = out_ready;
		end else begin : g_mid
			assign nxt_rdy = load[k+1];
		end

		assign load[k] = !vld_s[k] || nxt_rdy;

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [S_W:0] part, diff;
			logic         ge;

			assign part     = (k == 0) ? {1'b0, prv_r[l]} : {prv_r[l], 1'b0};
			assign ge       = part >= {1'b0, prv_d};
			assign diff     = part - {1'b0, prv_d};
			assign nxt_r[l] = ge ? diff[S_W-1:0] : part[S_W-1:0];
			assign nxt_q[l] = {prv_q[l][Q_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (load[k]) begin
				vld_s[k] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (load[k]) begin
				div_s[k] <= prv_d;
				rem_s[k] <= nxt_r;
				quo_s[k] <= nxt_q;
				neg_s[k] <= prv_n;
				deg_s[k] <= prv_g;
			end
		end
	end

	assign in_ready      = load[0];
	assign out_valid     = vld_s[STAGES-1];
	assign out_word.neg  = neg_s[STAGES-1];
	assign out_word.quo  = quo_s[STAGES-1];
	assign out_word.deg  = deg_s[STAGES-1];

`ifndef NO_ASSERTIONS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[STAGES-1] && !deg_s[STAGES-1]) |->
			(rem_s[STAGES-1][0] < div_s[STAGES-1]) && (rem_s[STAGES-1][4] < div_s[STAGES-1]))
		else $error("remainder not below divisor");
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[STAGES-1] && !deg_s[STAGES-1] && quo_s[STAGES-1][0][Q_W-1]) |->
			(quo_s[STAGES-1][0][Q_W-2:0] == '0))
		else $error("quotient above unit ratio");
`endif

endmodule

FILE: design/qrm_round.sv
`timescale 1ns / 1ps
module qrm_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qrm_pkg::qrm_div_out_t in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qrm_pkg::qrm_mat_t     out_word
);
	import qrm_pkg::*;

	logic                            vld_s1;
	logic                            ld_s1;
	qrm_mat_t                        mat_s1;
	logic [LANES-1:0][OUT_W-1:0]     m_nxt;
	logic [LANES-1:0][Q_W:0]         qp1;
	logic [LANES-1:0][Q_W-1:0]       qr;
	logic [LANES-1:0][Q_W-1:0]       sat;

	assign ld_s1    = !vld_s1 || out_ready;
	assign in_ready = ld_s1;

	// quotient holds floor(2^15 * |n| / s); halve with rounding
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			qp1[l] = {1'b0, in_word.quo[l]} + (Q_W+1)'(1);
			qr[l]  = qp1[l][Q_W:1];
			sat[l] = (qr[l] > ONE_Q14) ? ONE_Q14 : qr[l];
			if (in_word.deg) begin
				m_nxt[l] = (l % 4 == 0) ? OUT_W'(ONE_Q14) : '0;
			end else begin
				m_nxt[l] = in_word.neg[l] ? OUT_W'(-sat[l]) : OUT_W'(sat[l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			mat_s1.m   <= m_nxt;
			mat_s1.deg <= in_word.deg;
		end
	end

	assign out_valid = vld_s1;
	assign out_word  = mat_s1;

endmodule

FILE: design/quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// channel  handshake                  word
// -------  -------------------------  -------------------------------------
// input    in_valid / in_ready        quat_x, quat_y, quat_z, quat_w
// output   out_valid / out_ready      m00..m22, degenerate
//
// One word per cycle sustained while out_ready is high; 3 front stages
// (products, sums, magnitude), 16 divider stages (one quotient bit each),
// 1 rounding stage. Each stage loads when empty or when the next one moves,
// so bubbles close up under a stall. Reset clears only the valid bits.
module quaternion_to_rotation_matrix_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               degenerate
);
	import qrm_pkg::*;

	qrm_div_in_t  front_word;
	qrm_div_out_t div_word;
	qrm_mat_t     mat_word;
	logic         front_valid, front_ready;
	logic         div_valid, div_ready;

	qrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.qx        (quat_x),
		.qy        (quat_y),
		.qz        (quat_z),
		.qw        (quat_w),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_word  (front_word)
	);

	qrm_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_word   (front_word),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_word  (div_word)
	);

	qrm_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_word   (div_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (mat_word)
	);

	assign m00        = mat_word.m[0];
	assign m01        = mat_word.m[1];
	assign m02        = mat_word.m[2];
	assign m10        = mat_word.m[3];
	assign m11        = mat_word.m[4];
	assign m12        = mat_word.m[5];
	assign m20        = mat_word.m[6];
	assign m21        = mat_word.m[7];
	assign m22        = mat_word.m[8];
	assign degenerate = mat_word.deg;

`ifndef NO_ASSERTIONS
	a_deg_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |->
			(m00 == 16'sd16384) && (m11 == 16'sd16384) && (m22 == 16'sd16384) &&
			(m01 == '0) && (m12 == '0) && (m20 == '0))
		else $error("degenerate word is not identity");
	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(m00 <= 16'sd16384) && (m00 >= -16'sd16384) &&
			(m11 <= 16'sd16384) && (m11 >= -16'sd16384) &&
			(m22 <= 16'sd16384) && (m22 >= -16'sd16384))
		else $error("diagonal element out of range");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import qrm_pkg::*;

	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [15:0] Z16 = '0;
	localparam logic [15:0] NEG_ONE = 16'(-int'(ONE_Q14));

	localparam logic [LANES-1:0][OUT_W-1:0] IDENT_M =
		{ONE_Q14, Z16, Z16, Z16, ONE_Q14, Z16, Z16, Z16, ONE_Q14};
	localparam logic [LANES-1:0][OUT_W-1:0] FLIP_X_M =
		{ONE_Q14, Z16, Z16, Z16, NEG_ONE, Z16, Z16, Z16, NEG_ONE};
	localparam logic [LANES-1:0][OUT_W-1:0] FLIP_Y_M =
		{NEG_ONE, Z16, Z16, Z16, ONE_Q14, Z16, Z16, Z16, NEG_ONE};
	localparam logic [LANES-1:0][OUT_W-1:0] FLIP_Z_M =
		{NEG_ONE, Z16, Z16, Z16, NEG_ONE, Z16, Z16, Z16, ONE_Q14};
	// equal components: 120 degree turn about the diagonal, axes cycle
	localparam logic [LANES-1:0][OUT_W-1:0] CYCLE_M =
		{Z16, Z16, ONE_Q14, ONE_Q14, Z16, Z16, Z16, ONE_Q14, Z16};

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] w;
		logic        known;
		qrm_mat_t    want;
	} quat_case_t;

	localparam int N_DIRECTED = 25;

	quat_case_t directed_cases [N_DIRECTED] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{IDENT_M, 1'b1}},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, '{IDENT_M, 1'b0}},
		'{16'sd0, 16'sd0, 16'sd0, 16'h8000, 1'b1, '{IDENT_M, 1'b0}},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 1'b1, '{IDENT_M, 1'b0}},
		'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{FLIP_X_M, 1'b0}},
		'{16'h8000, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{FLIP_X_M, 1'b0}},
		'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{FLIP_X_M, 1'b0}},
		'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1, '{FLIP_Y_M, 1'b0}},
		'{16'sd0, 16'hFFFF, 16'sd0, 16'sd0, 1'b1, '{FLIP_Y_M, 1'b0}},
		'{16'sd0, 16'sd0, 16'h8000, 16'sd0, 1'b1, '{FLIP_Z_M, 1'b0}},
		'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b1, '{FLIP_Z_M, 1'b0}},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, '{CYCLE_M, 1'b0}},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, '{CYCLE_M, 1'b0}},
		'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b1, '{CYCLE_M, 1'b0}},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{CYCLE_M, 1'b0}},
		'{16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 1'b0, '0},
		'{16'sd1, 16'sd1, 16'sd1, 16'sd0, 1'b0, '0},
		'{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0, '0},
		'{16'hFFFF, 16'sd2, 16'hFFFD, 16'sd4, 1'b0, '0},
		'{16'sd3, 16'sd0, 16'sd0, 16'sd4, 1'b0, '0},
		'{16'sd12345, 16'hA460, 16'sd3456, 16'h8AD0, 1'b0, '0},
		'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
		'{16'h8000, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '0},
		'{16'sd0, 16'sd0, 16'sd1, 16'hFFFF, 1'b0, '0}
	};

	const string ELEM_NAME [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] quat_x = '0;
	logic signed [15:0] quat_y = '0;
	logic signed [15:0] quat_z = '0;
	logic signed [15:0] quat_w = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic               degenerate;

	// expectation typed into the table travels with the word
	logic     word_known = 1'b0;
	qrm_mat_t word_want = '0;

	qrm_mat_t pending_mats [$];
	int       errors = 0;
	bit       calm = 1'b0;
	bit       hold_req = 1'b0;

	quaternion_to_rotation_matrix_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.quat_w     (quat_w),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.m00        (m00),
		.m01        (m01),
		.m02        (m02),
		.m10        (m10),
		.m11        (m11),
		.m12        (m12),
		.m20        (m20),
		.m21        (m21),
		.m22        (m22),
		.degenerate (degenerate)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// round(num * 2^14 / den), ties away from zero, clamped to one
	function automatic logic [15:0] ratio_q14(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * 2 * longint'(ONE_Q14) + den) / (2 * den);
		if (q > longint'(ONE_Q14))
			q = longint'(ONE_Q14);
		return (num < 0) ? 16'(-q) : 16'(q);
	endfunction

	function automatic qrm_mat_t rotation_of(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		longint x, y, z, w;
		longint xx, yy, zz, xy, xz, yz, xw, yw, zw, s;
		qrm_mat_t r;
		x = qx;
		y = qy;
		z = qz;
		w = qw;
		xx = x * x;
		yy = y * y;
		zz = z * z;
		xy = x * y;
		xz = x * z;
		yz = y * z;
		xw = x * w;
		yw = y * w;
		zw = z * w;
		s = xx + yy + zz + w * w;
		r.deg = (s == 0);
		if (s == 0) begin
			r.m = IDENT_M;
		end else begin
			r.m = {ratio_q14(s - 2 * (yy + zz), s), ratio_q14(2 * (xy - zw), s),
				ratio_q14(2 * (xz + yw), s), ratio_q14(2 * (xy + zw), s),
				ratio_q14(s - 2 * (xx + zz), s), ratio_q14(2 * (yz - xw), s),
				ratio_q14(2 * (xz - yw), s), ratio_q14(2 * (yz + xw), s),
				ratio_q14(s - 2 * (xx + yy), s)};
		end
		return r;
	endfunction

	always @(posedge clk) begin
		qrm_mat_t got;
		qrm_mat_t want;
		qrm_mat_t fresh;
		if (out_valid && out_ready) begin
			got.m = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
			got.deg = degenerate;
			if (pending_mats.size() == 0) begin
				$error("matrix word with no quaternion pending");
				errors++;
			end else begin
				want = pending_mats.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (got.m[8-k] !== want.m[8-k]) begin
						$error("%s expected %0d actual %0d", ELEM_NAME[k],
							$signed(want.m[8-k]), $signed(got.m[8-k]));
						errors++;
					end
				end
				if (got.deg !== want.deg) begin
					$error("degenerate expected %0b actual %0b", want.deg, got.deg);
					errors++;
				end
			end
		end
		if (in_valid && in_ready) begin
			fresh = word_known ? word_want
				: rotation_of(quat_x, quat_y, quat_z, quat_w);
			pending_mats.insert(pending_mats.size(), fresh);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic offer(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input logic [15:0] w, input logic known, input qrm_mat_t want);
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		quat_w <= w;
		word_known <= known;
		word_want <= want;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (!calm && !hold_req && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_component();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom);
			5, 6: return 16'($urandom_range(0, 128) - 64);
			7: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					3: return 16'h0001;
					default: return '0;
				endcase
			end
			default: return '0;
		endcase
	endfunction

	task automatic random_quats(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) == 0)
				offer('0, '0, '0, '0, 1'b0, '0);
			else
				offer(pick_component(), pick_component(), pick_component(),
					pick_component(), 1'b0, '0);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			offer(directed_cases[i].x, directed_cases[i].y, directed_cases[i].z,
				directed_cases[i].w, directed_cases[i].known, directed_cases[i].want);

		random_quats(400);

		// sink stalls while words keep coming, pipeline backs up
		hold_req = 1'b1;
		random_quats(60);
		in_valid <= 1'b0;
		while (pending_mats.size() != 0) @(posedge clk);

		random_quats(450);

		calm = 1'b1;
		random_quats(150);
		in_valid <= 1'b0;

		while (pending_mats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
